// ----- rtl/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16 decoder: word types of both channels,
// the result queue depth and the code constants used by the decode logic.
// No dependencies.
`default_nettype none

package u8u16_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } byte_word_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        bad_input;
        logic        last_unit;
    } unit_word_t;

    // Result queue holds up to this many units; a pair needs two free slots.
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [4:0]  MaxPlane     = 5'h10;
    localparam logic [19:0] SuppBase     = 20'h10000;
    localparam logic [5:0]  HighSurrTag  = 6'b110110;
    localparam logic [5:0]  LowSurrTag   = 6'b110111;
    localparam logic [2:0]  LeadTwo      = 3'b110;
    localparam logic [3:0]  LeadThree    = 4'b1110;
    localparam logic [4:0]  LeadFour     = 5'b11110;
    localparam logic [1:0]  ContTag      = 2'b10;

endpackage

`default_nettype wire

// ----- rtl/utf8_to_utf16_decoder.sv -----
// UTF-8 to UTF-16 decoder top level: input register, decode logic and a
// small result queue. Depends on u8u16_pkg for word types and constants.
//
//  Channel | Signals                              | Word
//  --------+--------------------------------------+---------------------------
//  bytes   | byte_valid, byte_stall, byte_data    | in_byte, stream_end
//  units   | unit_valid, unit_stall, unit_data    | code_unit, bad_input, last
//
// A byte word is taken into the input register and decoded from there; its
// units are written to the result queue register and leave from it. One byte
// word is taken per cycle while byte_stall is low; the single output port of
// the result queue sets the sustained rate; a surrogate pair is two units.
// Reset clears the decode state, the sticky error and the queue.
// byte_stall rises only while the queue lacks room for two units.
`default_nettype none

module utf8_to_utf16_decoder (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire u8u16_pkg::byte_word_t byte_data,
    output logic                       unit_valid,
    input  wire logic                  unit_stall,
    output u8u16_pkg::unit_word_t      unit_data
);

    localparam int unsigned PtrW = u8u16_pkg::QueuePtrW;
    localparam int unsigned CntW = u8u16_pkg::QueueCntW;

    // Input register.
    logic                  in_valid_reg;
    u8u16_pkg::byte_word_t in_word_reg;

    // Decode state.
    logic [1:0]  bytes_left_reg, bytes_left_next;
    logic [20:0] partial_reg, partial_next;
    logic        error_reg, error_next;
    logic        four_reg, four_next;

    // Result queue.
    u8u16_pkg::unit_word_t queue_reg [u8u16_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    logic                  fire, pop, take;
    logic [1:0]            num_res;
    u8u16_pkg::unit_word_t res0, res1;
    logic                  do_fail;
    logic [20:0]           pc_cat;
    logic [1:0]            bl_dec;
    logic [19:0]           supp;
    logic [7:0]            b;

    assign fire       = in_valid_reg && (count_reg <= CntW'(u8u16_pkg::QueueDepth - 2));
    assign byte_stall = in_valid_reg && !fire;
    assign take       = byte_valid && !byte_stall;
    assign unit_valid = (count_reg != '0);
    assign unit_data  = queue_reg[rd_ptr_reg];
    assign pop        = unit_valid && !unit_stall;

    assign b      = in_word_reg.in_byte;
    assign pc_cat = {partial_reg[14:0], b[5:0]};
    assign bl_dec = bytes_left_reg - 2'd1;
    assign supp   = pc_cat[19:0] - u8u16_pkg::SuppBase;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        partial_next    = partial_reg;
        error_next      = error_reg;
        four_next       = four_reg;
        num_res         = 2'd0;
        res0            = '0;
        res1            = '0;
        do_fail         = 1'b0;

        if (in_word_reg.stream_end)
        begin
            do_fail = error_reg || (bytes_left_reg != 2'd0);
        end
        else if (error_reg)
        begin
            do_fail = 1'b1;
        end
        else if (bytes_left_reg == 2'd0)
        begin
            if (!b[7])
            begin
                num_res = 2'd1;
                res0    = '{code_unit: {8'h00, b}, bad_input: 1'b0, last_unit: 1'b1};
            end
            else if (b[7:5] == u8u16_pkg::LeadTwo)
            begin
                partial_next    = {16'h0, b[4:0]};
                bytes_left_next = 2'd1;
                four_next       = 1'b0;
            end
            else if (b[7:4] == u8u16_pkg::LeadThree)
            begin
                partial_next    = {17'h0, b[3:0]};
                bytes_left_next = 2'd2;
                four_next       = 1'b0;
            end
            else if (b[7:3] == u8u16_pkg::LeadFour)
            begin
                partial_next    = {18'h0, b[2:0]};
                bytes_left_next = 2'd3;
                four_next       = 1'b1;
            end
            else
            begin
                do_fail = 1'b1;
            end
        end
        else if (b[7:6] != u8u16_pkg::ContTag)
        begin
            do_fail = 1'b1;
        end
        else if (bl_dec != 2'd0)
        begin
            partial_next    = pc_cat;
            bytes_left_next = bl_dec;
        end
        else if (!four_reg)
        begin
            num_res         = 2'd1;
            res0            = '{code_unit: pc_cat[15:0], bad_input: 1'b0, last_unit: 1'b1};
            partial_next    = '0;
            bytes_left_next = 2'd0;
        end
        else if (pc_cat[20:16] > u8u16_pkg::MaxPlane)
        begin
            do_fail = 1'b1;
        end
        else
        begin
            // Surrogate pair: high half first, marked as not the last unit.
            num_res         = 2'd2;
            res0            = '{code_unit: {u8u16_pkg::HighSurrTag, supp[19:10]},
                                bad_input: 1'b0, last_unit: 1'b0};
            res1            = '{code_unit: {u8u16_pkg::LowSurrTag, supp[9:0]},
                                bad_input: 1'b0, last_unit: 1'b1};
            partial_next    = '0;
            bytes_left_next = 2'd0;
            four_next       = 1'b0;
        end

        if (do_fail)
        begin
            error_next      = 1'b1;
            bytes_left_next = 2'd0;
            partial_next    = '0;
            four_next       = 1'b0;
            num_res         = 2'd1;
            res0            = '{code_unit: 16'h0000, bad_input: 1'b1, last_unit: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            bytes_left_reg <= '0;
            partial_reg    <= '0;
            error_reg      <= 1'b0;
            four_reg       <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                bytes_left_reg <= bytes_left_next;
                partial_reg    <= partial_next;
                error_reg      <= error_next;
                four_reg       <= four_next;
                wr_ptr_reg     <= wr_ptr_reg + PtrW'(num_res);
            end

            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end

            count_reg <= count_reg + (fire ? CntW'(num_res) : CntW'(0))
                       - (pop ? CntW'(1) : CntW'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= byte_data;
        end
        if (fire && (num_res != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (fire && (num_res == 2'd2))
        begin
            queue_reg[wr_ptr_reg + PtrW'(1)] <= res1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(u8u16_pkg::QueueDepth))
        else $error("result queue count beyond depth");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("sticky error cleared without reset");

    a_error_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> (bytes_left_reg == 2'd0) && !four_reg)
        else $error("open sequence while error stands");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && unit_data.bad_input) |-> (unit_data.code_unit == 16'h0000)
            && unit_data.last_unit)
        else $error("error word with nonzero unit");
`endif

endmodule

`default_nettype wire
